/* hdl/saws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package saws_pkg;

  // Event codes on the input func field
  localparam logic [1:0] FUNC_NEW_FRAME = 2'd0;
  localparam logic [1:0] FUNC_TX_DONE   = 2'd1;
  localparam logic [1:0] FUNC_RX_FRAME  = 2'd2;
  localparam logic [1:0] FUNC_TICK      = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_RELIABLE_MODE = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_MAX_TX        = 2'd2;

  localparam int CFG_WIDTH = 16;

  localparam logic        RST_RELIABLE_MODE = 1'b1;
  localparam logic [15:0] RST_ACK_TIMEOUT   = 16'd100;
  localparam logic [7:0]  RST_MAX_TX        = 8'd3;

  // Outcome codes
  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_ACKED = 2'd1;
  localparam logic [1:0] OUT_LOST  = 2'd2;
  localparam logic [1:0] OUT_DONE  = 2'd3;

  // Note codes
  localparam logic [2:0] NOTE_OK         = 3'd0;
  localparam logic [2:0] NOTE_IGNORED    = 3'd1;
  localparam logic [2:0] NOTE_OLD        = 3'd2;
  localparam logic [2:0] NOTE_FUTURE     = 3'd3;
  localparam logic [2:0] NOTE_NOT_ACK    = 3'd4;
  localparam logic [2:0] NOTE_BUSY       = 3'd5;
  localparam logic [2:0] NOTE_UNEXPECTED = 3'd6;

  // Queue depths
  localparam int EV_DEPTH_DEF  = 2;
  localparam int RES_DEPTH_DEF = 2;

  // Classified event, as the front hands it to the back
  typedef enum logic [2:0] {
    EV_NEW     = 3'd0,
    EV_TX_DONE = 3'd1,
    EV_ACK     = 3'd2,
    EV_NOT_ACK = 3'd3,
    EV_TICK    = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [31:0] seq;
  } ev_t;

  typedef struct packed {
    logic        send_request;
    logic [31:0] send_seq;
    logic [1:0]  outcome;
    logic [2:0]  note;
    logic        busy_res;
    logic [31:0] sent_total;
    logic [31:0] retransmit_total;
    logic [31:0] lost_total;
    logic [31:0] received_total;
  } res_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [CFG_WIDTH-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

/* hdl/saws_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module saws_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/saws_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module saws_front (
  input  wire logic        in_push,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_frame_is_ack,
  input  wire logic        evq_full,
  output logic             evq_push,
  output saws_pkg::ev_t    evq_data
);

  import saws_pkg::*;

  // received frames split into acks and the rest here, so the back sees them as two kinds
  always_comb begin
    evq_data.seq = in_seq_number;
    case (in_func)
      FUNC_NEW_FRAME: evq_data.kind = EV_NEW;
      FUNC_TX_DONE:   evq_data.kind = EV_TX_DONE;
      FUNC_RX_FRAME:  evq_data.kind = in_frame_is_ack ? EV_ACK : EV_NOT_ACK;
      FUNC_TICK:      evq_data.kind = EV_TICK;
      default:        evq_data.kind = EV_TICK;
    endcase
  end

  assign evq_push = in_push && !evq_full;

endmodule

`default_nettype wire

/* hdl/saws_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module saws_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  saws_pkg::cfg_wr_t  cfg,
  input  wire logic          evq_empty,
  input  saws_pkg::ev_t      evq_data,
  output logic               evq_pop,
  input  wire logic          resq_full,
  output logic               resq_push,
  output saws_pkg::res_t     resq_data
);

  import saws_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_WAIT_TX  = 3'b010,
    PH_WAIT_ACK = 3'b100
  } phase_t;

  logic        reliable_r;
  logic [15:0] timeout_r;
  logic [7:0]  max_tx_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [15:0] timer_r, timer_nxt, timer_dec;
  logic [31:0] sent_r, sent_nxt;
  logic [31:0] retx_r, retx_nxt;
  logic [31:0] lost_r, lost_nxt;
  logic [31:0] recv_r, recv_nxt;
  logic        req;
  logic [1:0]  outcome;
  logic [2:0]  note;
  logic        go;

  assign go        = !evq_empty && !resq_full;
  assign evq_pop   = go;
  assign resq_push = go;
  assign timer_dec = (timer_r != '0) ? timer_r - 16'd1 : timer_r;

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    tries_nxt = tries_r;
    timer_nxt = timer_r;
    sent_nxt  = sent_r;
    retx_nxt  = retx_r;
    lost_nxt  = lost_r;
    recv_nxt  = recv_r;
    req       = 1'b0;
    outcome   = OUT_NONE;
    note      = NOTE_OK;
    if (go) begin
      case (evq_data.kind)
        EV_NEW: begin
          if (phase_r != PH_IDLE) begin
            note = NOTE_BUSY;
          end else begin
            seq_nxt   = evq_data.seq;
            tries_nxt = 8'd1;
            phase_nxt = PH_WAIT_TX;
            sent_nxt  = sent_r + 32'd1;
            req       = 1'b1;
          end
        end
        EV_TX_DONE: begin
          if (phase_r != PH_WAIT_TX) begin
            note = NOTE_UNEXPECTED;
          end else if (!reliable_r) begin
            phase_nxt = PH_IDLE;
            outcome   = OUT_DONE;
          end else begin
            phase_nxt = PH_WAIT_ACK;
            timer_nxt = (timeout_r == '0) ? 16'd1 : timeout_r;
          end
        end
        EV_ACK: begin
          recv_nxt = recv_r + 32'd1;
          if (phase_r != PH_WAIT_ACK) begin
            note = NOTE_IGNORED;
          end else if (evq_data.seq == seq_r) begin
            phase_nxt = PH_IDLE;
            outcome   = OUT_ACKED;
          end else if (evq_data.seq < seq_r) begin
            note = NOTE_OLD;
          end else begin
            note = NOTE_FUTURE;
          end
        end
        EV_NOT_ACK: begin
          note = NOTE_NOT_ACK;
        end
        EV_TICK: begin
          if (phase_r == PH_WAIT_ACK) begin
            timer_nxt = timer_dec;
            if (timer_dec == '0) begin
              if (tries_r >= max_tx_r) begin
                lost_nxt  = lost_r + 32'd1;
                phase_nxt = PH_IDLE;
                outcome   = OUT_LOST;
              end else begin
                retx_nxt  = retx_r + 32'd1;
                tries_nxt = tries_r + 8'd1;
                phase_nxt = PH_WAIT_TX;
                sent_nxt  = sent_r + 32'd1;
                req       = 1'b1;
              end
            end
          end
        end
        default: begin
          note = NOTE_OK;
        end
      endcase
    end
  end

  always_comb begin
    resq_data.send_request     = req;
    resq_data.send_seq         = seq_nxt;
    resq_data.outcome          = outcome;
    resq_data.note             = note;
    resq_data.busy_res         = (phase_nxt != PH_IDLE);
    resq_data.sent_total       = sent_nxt;
    resq_data.retransmit_total = retx_nxt;
    resq_data.lost_total       = lost_nxt;
    resq_data.received_total   = recv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reliable_r <= RST_RELIABLE_MODE;
      timeout_r  <= RST_ACK_TIMEOUT;
      max_tx_r   <= RST_MAX_TX;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_RELIABLE_MODE: reliable_r <= cfg.wdata[0];
        CFG_ACK_TIMEOUT:   timeout_r  <= cfg.wdata[15:0];
        CFG_MAX_TX:        max_tx_r   <= cfg.wdata[7:0];
        default:           reliable_r <= reliable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seq_r   <= '0;
      tries_r <= '0;
      timer_r <= '0;
      sent_r  <= '0;
      retx_r  <= '0;
      lost_r  <= '0;
      recv_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      tries_r <= tries_nxt;
      timer_r <= timer_nxt;
      sent_r  <= sent_nxt;
      retx_r  <= retx_nxt;
      lost_r  <= lost_nxt;
      recv_r  <= recv_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/stop_and_wait_arq_sender.sv */
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+-------------------------
// events    | in_func, in_seq_number, in_frame_is_ack            | in_push & !in_full
// results   | out_send_request ... out_received_total            | out_pop & !out_empty
// config    | cfg_index, cfg_wdata                               | cfg_we, no wait
//
// One event per clock while results are popped; each event gives exactly one result item.
// An accepted event is registered in the event queue; the engine, between the queues, pops
// it when the result queue has room and registers its result there, one event a cycle.
// Synchronous active-low reset clears the protocol state, counters and both queues.
// A stalled result consumer fills the result queue, then the event queue, then raises in_full.
`timescale 1ns / 1ps
`default_nettype none

module stop_and_wait_arq_sender #(
  parameter int EV_DEPTH  = saws_pkg::EV_DEPTH_DEF,
  parameter int RES_DEPTH = saws_pkg::RES_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // event channel
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_frame_is_ack,
  // result channel
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_send_request,
  output logic [31:0]      out_send_seq,
  output logic [1:0]       out_outcome,
  output logic [2:0]       out_note,
  output logic             out_busy_res,
  output logic [31:0]      out_sent_total,
  output logic [31:0]      out_retransmit_total,
  output logic [31:0]      out_lost_total,
  output logic [31:0]      out_received_total,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [saws_pkg::CFG_WIDTH-1:0] cfg_wdata
);

  import saws_pkg::*;

  // front: decode and push into the event queue
  logic    evq_push, evq_full, evq_pop, evq_empty;
  ev_t     evq_wdata, evq_rdata;
  // back: engine and result queue
  logic    resq_push, resq_full;
  res_t    resq_wdata, resq_rdata;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  saws_front u_front (
    .in_push         (in_push),
    .in_func         (in_func),
    .in_seq_number   (in_seq_number),
    .in_frame_is_ack (in_frame_is_ack),
    .evq_full        (evq_full),
    .evq_push        (evq_push),
    .evq_data        (evq_wdata)
  );

  assign in_full = evq_full;

  // decouples the accept side from the engine
  saws_fifo #(
    .W     ($bits(ev_t)),
    .DEPTH (EV_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (evq_push),
    .wdata (evq_wdata),
    .full  (evq_full),
    .pop   (evq_pop),
    .rdata (evq_rdata),
    .empty (evq_empty)
  );

  // protocol engine: phase, sequence, tries, ack timer, statistics
  saws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .evq_empty (evq_empty),
    .evq_data  (evq_rdata),
    .evq_pop   (evq_pop),
    .resq_full (resq_full),
    .resq_push (resq_push),
    .resq_data (resq_wdata)
  );

  // result items wait here, so the engine keeps going while the consumer stalls, until this queue fills
  saws_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (resq_push),
    .wdata (resq_wdata),
    .full  (resq_full),
    .pop   (out_pop),
    .rdata (resq_rdata),
    .empty (out_empty)
  );

  assign out_send_request     = resq_rdata.send_request;
  assign out_send_seq         = resq_rdata.send_seq;
  assign out_outcome          = resq_rdata.outcome;
  assign out_note             = resq_rdata.note;
  assign out_busy_res         = resq_rdata.busy_res;
  assign out_sent_total       = resq_rdata.sent_total;
  assign out_retransmit_total = resq_rdata.retransmit_total;
  assign out_lost_total       = resq_rdata.lost_total;
  assign out_received_total   = resq_rdata.received_total;

endmodule

`default_nettype wire

/* hdl/saws_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module saws_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic        out_send_request,
  input wire logic [31:0] out_send_seq,
  input wire logic [1:0]  out_outcome,
  input wire logic [2:0]  out_note,
  input wire logic        out_busy_res
);

  import saws_pkg::*;

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a finished frame always leaves the sender idle
  a_outcome_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_outcome != OUT_NONE) |-> (!out_busy_res && out_note == NOTE_OK))
    else $error("outcome reported while still busy");

  // a send request means a frame is in flight and nothing else happened
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_send_request) |-> (out_busy_res && out_outcome == OUT_NONE))
    else $error("send request without busy");

  // a rejected new frame only happens while busy
  a_busy_note: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_note == NOTE_BUSY) |-> (out_busy_res && !out_send_request))
    else $error("busy note while idle");

  // head item holds while not taken
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_send_seq)
                                  && $stable(out_note)))
    else $error("result head changed while stalled");

endmodule

bind stop_and_wait_arq_sender saws_checker u_saws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_send_request (out_send_request),
  .out_send_seq     (out_send_seq),
  .out_outcome      (out_outcome),
  .out_note         (out_note),
  .out_busy_res     (out_busy_res)
);

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import saws_pkg::*;

  // Sender phase as tracked by the predictor
  typedef enum logic [1:0] {
    LINK_IDLE     = 2'd0,
    LINK_WAIT_TX  = 2'd1,
    LINK_WAIT_ACK = 2'd2
  } link_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [31:0] in_seq_number;
  logic        in_frame_is_ack;
  logic        out_empty;
  logic        out_pop;
  logic        out_send_request;
  logic [31:0] out_send_seq;
  logic [1:0]  out_outcome;
  logic [2:0]  out_note;
  logic        out_busy_res;
  logic [31:0] out_sent_total;
  logic [31:0] out_retransmit_total;
  logic [31:0] out_lost_total;
  logic [31:0] out_received_total;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  stop_and_wait_arq_sender i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_func              (in_func),
    .in_seq_number        (in_seq_number),
    .in_frame_is_ack      (in_frame_is_ack),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_send_request     (out_send_request),
    .out_send_seq         (out_send_seq),
    .out_outcome          (out_outcome),
    .out_note             (out_note),
    .out_busy_res         (out_busy_res),
    .out_sent_total       (out_sent_total),
    .out_retransmit_total (out_retransmit_total),
    .out_lost_total       (out_lost_total),
    .out_received_total   (out_received_total),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // Predictor copy of the sender: configuration, protocol state, counters
  logic        arq_reliable = RST_RELIABLE_MODE;
  logic [15:0] arq_timeout  = RST_ACK_TIMEOUT;
  logic [7:0]  arq_max_tx   = RST_MAX_TX;
  link_phase_t lk_phase     = LINK_IDLE;
  logic [31:0] lk_seq       = '0;
  logic [7:0]  lk_tries     = '0;
  logic [15:0] lk_timer     = '0;
  logic [31:0] lk_sent      = '0;
  logic [31:0] lk_retx      = '0;
  logic [31:0] lk_lost      = '0;
  logic [31:0] lk_rcvd      = '0;

  res_t sender_reports_q[$];  // expected result items, oldest first
  int   mismatches = 0;
  int   items_sent = 0;
  int   send_idle_pct = 0;    // chance per try that the sender idles before offering an item
  int   pop_stall_pct = 0;    // chance the receiver skips a pop

  always #6 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Receiver: pop decided at the falling edge, sampled by the block at the rising one.
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
  end

  task automatic launch_frame();
    lk_phase = LINK_WAIT_TX;
    lk_tries = lk_tries + 8'd1;
    lk_sent  = lk_sent + 32'd1;
  endtask

  // Apply one accepted event to the predictor and queue the report it gives.
  task automatic advance_arq(input logic [1:0] func, input logic [31:0] seq,
                             input logic is_ack);
    res_t rep;
    rep = '0;
    rep.outcome = OUT_NONE;
    rep.note    = NOTE_OK;
    case (func)
      FUNC_NEW_FRAME: begin
        if (lk_phase != LINK_IDLE) begin
          rep.note = NOTE_BUSY;
        end else begin
          lk_seq   = seq;
          lk_tries = '0;
          launch_frame();
          rep.send_request = 1'b1;
        end
      end
      FUNC_TX_DONE: begin
        if (lk_phase != LINK_WAIT_TX) begin
          rep.note = NOTE_UNEXPECTED;
        end else if (!arq_reliable) begin
          lk_phase    = LINK_IDLE;
          rep.outcome = OUT_DONE;
        end else begin
          lk_phase = LINK_WAIT_ACK;
          lk_timer = (arq_timeout == 16'd0) ? 16'd1 : arq_timeout;
        end
      end
      FUNC_RX_FRAME: begin
        if (!is_ack) begin
          rep.note = NOTE_NOT_ACK;
        end else begin
          lk_rcvd = lk_rcvd + 32'd1;
          if (lk_phase != LINK_WAIT_ACK) begin
            rep.note = NOTE_IGNORED;
          end else if (seq == lk_seq) begin
            lk_phase    = LINK_IDLE;
            rep.outcome = OUT_ACKED;
          end else if (seq < lk_seq) begin
            rep.note = NOTE_OLD;
          end else begin
            rep.note = NOTE_FUTURE;
          end
        end
      end
      default: begin
        // tick: only the ack wait counts down
        if (lk_phase == LINK_WAIT_ACK) begin
          if (lk_timer != 16'd0) lk_timer = lk_timer - 16'd1;
          if (lk_timer == 16'd0) begin
            // a zero limit behaves as one
            if (lk_tries >= arq_max_tx) begin
              lk_lost     = lk_lost + 32'd1;
              lk_phase    = LINK_IDLE;
              rep.outcome = OUT_LOST;
            end else begin
              lk_retx = lk_retx + 32'd1;
              launch_frame();
              rep.send_request = 1'b1;
            end
          end
        end
      end
    endcase
    rep.send_seq         = lk_seq;
    rep.busy_res         = (lk_phase != LINK_IDLE);
    rep.sent_total       = lk_sent;
    rep.retransmit_total = lk_retx;
    rep.lost_total       = lk_lost;
    rep.received_total   = lk_rcvd;
    sender_reports_q.push_back(rep);
  endtask

  // Offer one item, starting at a falling edge. Returns at the falling edge
  // after acceptance with push still high, so back-to-back items need no gap.
  task automatic send_event(input logic [1:0] func, input logic [31:0] seq,
                            input logic is_ack);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push         <= 1'b1;
    in_func         <= func;
    in_seq_number   <= seq;
    in_frame_is_ack <= is_ack;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    advance_arq(func, seq, is_ack);
    items_sent++;
  endtask

  // Stop sending and wait for every expected item, plus the pipeline depth.
  task automatic settle();
    in_push <= 1'b0;
    while (sender_reports_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called while settled.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_RELIABLE_MODE: arq_reliable = val[0];
      CFG_ACK_TIMEOUT:   arq_timeout  = val[15:0];
      CFG_MAX_TX:        arq_max_tx   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, fname, want, got);
    end
  endtask

  // Every popped item is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (sender_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result item with none expected", $realtime);
      end else begin
        want = sender_reports_q.pop_front();
        check_field("send_request", 32'(want.send_request), 32'(out_send_request));
        check_field("send_seq", want.send_seq, out_send_seq);
        check_field("outcome", 32'(want.outcome), 32'(out_outcome));
        check_field("note", 32'(want.note), 32'(out_note));
        check_field("busy_res", 32'(want.busy_res), 32'(out_busy_res));
        check_field("sent_total", want.sent_total, out_sent_total);
        check_field("retransmit_total", want.retransmit_total, out_retransmit_total);
        check_field("lost_total", want.lost_total, out_lost_total);
        check_field("received_total", want.received_total, out_received_total);
      end
    end
  end

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_noise();
    send_event(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Corner cases in a fixed order: stray events, busy, old and future acks,
  // zero limits, unreliable finish and a mode switch while in flight.
  task automatic test_directed();
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);           // notice while idle
    send_event(FUNC_RX_FRAME, 32'h0, 1'b1);          // ack while idle
    send_event(FUNC_RX_FRAME, 32'hFFFF_FFFF, 1'b0);  // non-ack frame
    send_event(FUNC_TICK, 32'hFFFF_FFFF, 1'b1);      // tick while idle
    send_event(FUNC_NEW_FRAME, 32'hFFFF_FFFF, 1'b1);
    send_event(FUNC_NEW_FRAME, 32'h1234_5678, 1'b0); // rejected, busy
    send_event(FUNC_RX_FRAME, 32'hFFFF_FFFF, 1'b1);  // ack before the notice
    send_event(FUNC_TX_DONE, 32'h0, 1'b1);
    send_event(FUNC_RX_FRAME, 32'h0, 1'b1);          // old ack
    send_event(FUNC_RX_FRAME, 32'hFFFF_FFFF, 1'b1);  // acked
    send_event(FUNC_NEW_FRAME, 32'h0, 1'b0);
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);
    send_event(FUNC_RX_FRAME, 32'h1, 1'b1);          // future ack
    send_event(FUNC_RX_FRAME, 32'h0, 1'b1);          // acked
    settle();
    write_reg(CFG_ACK_TIMEOUT, '0);
    write_reg(CFG_MAX_TX, '0);
    send_event(FUNC_NEW_FRAME, 32'h5555_AAAA, 1'b0);
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);
    send_event(FUNC_TICK, 32'h0, 1'b0);              // first timeout loses it
    settle();
    write_reg(CFG_RELIABLE_MODE, '0);
    send_event(FUNC_NEW_FRAME, 32'hAAAA_5555, 1'b1);
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);           // done, unreliable
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);           // stray notice
    send_event(FUNC_NEW_FRAME, 32'h0000_8000, 1'b0);
    settle();
    // mode is taken at the notice, not when the frame arrived
    write_reg(CFG_RELIABLE_MODE, 16'd1);
    write_reg(CFG_MAX_TX, 16'd2);
    send_event(FUNC_TX_DONE, 32'h0, 1'b1);
    send_event(FUNC_TICK, 32'h0, 1'b0);              // retransmit
    send_event(FUNC_TX_DONE, 32'h0, 1'b0);
    send_event(FUNC_TICK, 32'h0, 1'b0);              // lost after two sends
    settle();
  endtask

  // Largest timeout and transmission limit; frames end by ack only.
  task automatic test_config_extremes();
    write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
    write_reg(CFG_MAX_TX, 16'd255);
    repeat (4) begin
      send_event(FUNC_NEW_FRAME, pick_seq(), 1'($urandom_range(0, 1)));
      send_event(FUNC_TX_DONE, $urandom, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) send_event(FUNC_TICK, $urandom, 1'b0);
      send_event(FUNC_RX_FRAME, lk_seq, 1'b1);
    end
    settle();
  endtask

  // One frame driven through its life with random detours along the way.
  task automatic run_frame();
    int steps;
    int r;
    send_event(FUNC_NEW_FRAME, pick_seq(), 1'($urandom_range(0, 1)));
    steps = 0;
    while (lk_phase != LINK_IDLE && steps < 60) begin
      r = $urandom_range(0, 99);
      steps++;
      if (lk_phase == LINK_WAIT_TX) begin
        if (r < 80) send_event(FUNC_TX_DONE, $urandom, 1'($urandom_range(0, 1)));
        else send_noise();
      end else if (r < 25) begin
        send_event(FUNC_RX_FRAME, lk_seq, 1'b1);
      end else if (r < 70) begin
        send_event(FUNC_TICK, $urandom, 1'($urandom_range(0, 1)));
      end else if (r < 78 && lk_seq != 32'h0) begin
        send_event(FUNC_RX_FRAME, $urandom_range(0, lk_seq - 32'd1), 1'b1);
      end else if (r < 86 && lk_seq != 32'hFFFF_FFFF) begin
        send_event(FUNC_RX_FRAME, $urandom_range(lk_seq + 32'd1, 32'hFFFF_FFFF), 1'b1);
      end else begin
        send_noise();
      end
    end
  endtask

  // Random frames under one idling pattern, reconfigured every so often.
  // Each reconfiguration drains the block first.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int start;
    int next_cfg;
    int lim;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    start    = items_sent;
    next_cfg = items_sent;
    while (items_sent - start < n_items) begin
      if (items_sent >= next_cfg) begin
        settle();
        write_reg(CFG_RELIABLE_MODE, CFG_WIDTH'($urandom_range(0, 3) != 0));
        write_reg(CFG_ACK_TIMEOUT,
                  CFG_WIDTH'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8)));
        lim = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 5);
        write_reg(CFG_MAX_TX, CFG_WIDTH'(lim));
        next_cfg = items_sent + $urandom_range(80, 160);
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_noise();
      else run_frame();
    end
    settle();
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_func         = FUNC_TICK;
    in_seq_number   = '0;
    in_frame_is_ack = 1'b0;
    out_pop         = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_RELIABLE_MODE;
    cfg_wdata       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_random_traffic(9, 56, 400);
    test_random_traffic(56, 9, 400);
    test_random_traffic(0, 0, 400);

    if (mismatches == 0 && sender_reports_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/saws_pkg.sv
hdl/saws_fifo.sv
hdl/saws_front.sv
hdl/saws_back.sv
hdl/stop_and_wait_arq_sender.sv
hdl/saws_checker.sv
dv/testbench.sv
